// ===== src/hdrf_pkg.sv =====
// hdrf_pkg: shared types and constants of the hid descriptor report id filter
// no dependencies; used by the interfaces, the top level and the testbench
package hdrf_pkg;

  localparam int MAX_IDS_DEF = 16;
  localparam int ID_W        = 24;
  localparam int OP_W        = 2;
  localparam int BYTE_W      = 8;
  localparam int COUNT_OUT_W = 5;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [ID_W-1:0] VENDOR_PAGE_RESET = 24'h0000FF;
  localparam logic [5:0]      TAG_PAGE          = 6'd1;
  localparam logic [5:0]      TAG_RID           = 6'd33;
  localparam logic            REG_VENDOR_PAGE   = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_BYTE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_PAGE  = 2'd1,
    KIND_RID   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHECK = 2'd1,
    S_EMIT  = 2'd2
  } state_t;

endpackage

// ===== src/hdrf_in_if.sv =====
// hdrf_in_if: valid/ready channel carrying one input word (operation, data byte)
// depends on hdrf_pkg
interface hdrf_in_if;
  import hdrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, operation, data_byte, input ready);
  modport sink   (input valid, operation, data_byte, output ready);
endinterface

// ===== src/hdrf_out_if.sv =====
// hdrf_out_if: valid/ready channel carrying one result word
// depends on hdrf_pkg
interface hdrf_out_if;
  import hdrf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   id_valid;
  logic [COUNT_OUT_W-1:0] ids_stored;
  logic                   table_overflow;

  modport source (output valid, id_valid, ids_stored, table_overflow, input ready);
  modport sink   (input valid, id_valid, ids_stored, table_overflow, output ready);
endinterface

// ===== src/hdrf_ram.sv =====
// hdrf_ram: generic single write port, single read port ram with registered read
// no dependencies
module hdrf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hid_descriptor_report_id_filter_unit.sv =====
// hid_descriptor_report_id_filter_unit: short item parser with report id table
// depends on hdrf_pkg, hdrf_in_if, hdrf_out_if, hdrf_ram
// clear, descriptor byte and unused op: accept moves to S_EMIT, which loads the result
// check: S_CHECK scans the table, one table entry read and compared per cycle
// through the single read port of the id table ram; one word in flight at a time
// synchronous reset clears parser, usage page, count, overflow; vendor_page to 0xff
module hid_descriptor_report_id_filter_unit #(
  parameter int MAX_IDS = hdrf_pkg::MAX_IDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  hdrf_in_if.sink                     req,
  hdrf_out_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdrf_pkg::ADDR_W-1:0] paddr,
  input  logic [hdrf_pkg::DATA_W-1:0] pwdata,
  output logic [hdrf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import hdrf_pkg::*;

  localparam int CNT_W = $clog2(MAX_IDS + 1);
  localparam int AW    = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

  state_t state, state_next;

  logic [ID_W-1:0]  vendor_page;
  logic [1:0]       bytes_left, bytes_left_next;
  kind_t            item_kind, item_kind_next;
  logic [ID_W-1:0]  item_value, item_value_next;
  logic [ID_W-1:0]  usage_page, usage_page_next;
  logic [CNT_W-1:0] id_count, id_count_next;
  logic             overflow_seen, overflow_seen_next;

  logic [CNT_W-1:0]  idx, idx_next;
  logic              cmp_ok, cmp_ok_next;
  logic              cmp_last, cmp_last_next;
  logic              res_hit, res_hit_next;
  logic [BYTE_W-1:0] chk_byte, chk_byte_next;

  logic                   out_valid;
  logic                   out_id_valid;
  logic [COUNT_OUT_W-1:0] out_ids;
  logic                   out_ovf;

  logic            accept;
  logic            clear_req;
  logic            byte_take;
  logic            out_load;
  logic            hit;
  logic            ram_we;
  logic [ID_W-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [ID_W-1:0] ram_rdata;
  logic [31:0]     cnt_ext;
  logic            cfg_we;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_VENDOR_PAGE);
  assign prdata = (paddr[2] == REG_VENDOR_PAGE) ? {{(DATA_W-ID_W){1'b0}}, vendor_page}
                                                : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_page <= VENDOR_PAGE_RESET;
    end else if (cfg_we) begin
      vendor_page <= pwdata[ID_W-1:0];
    end
  end

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid          = out_valid;
  assign rsp.id_valid       = out_id_valid;
  assign rsp.ids_stored     = out_ids;
  assign rsp.table_overflow = out_ovf;

  assign hit     = (ram_rdata == {{(ID_W-BYTE_W){1'b0}}, chk_byte});
  assign cnt_ext = 32'(id_count);

  hdrf_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_IDS)
  ) u_id_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_count[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    cmp_ok_next   = cmp_ok;
    cmp_last_next = cmp_last;
    res_hit_next  = res_hit;
    chk_byte_next = chk_byte;
    ram_raddr     = idx[AW-1:0];
    clear_req     = 1'b0;
    byte_take     = 1'b0;
    out_load      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_hit_next = 1'b0;
          state_next   = S_EMIT;
          case (op_t'(req.operation))
            OP_CLEAR: clear_req = 1'b1;
            OP_BYTE:  byte_take = 1'b1;
            OP_CHECK: begin
              chk_byte_next = req.data_byte;
              idx_next      = '0;
              cmp_ok_next   = 1'b0;
              cmp_last_next = 1'b0;
              if (id_count != '0) begin
                state_next = S_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (cmp_ok && hit) begin
          res_hit_next = 1'b1;
          state_next   = S_EMIT;
        end else if (cmp_ok && cmp_last) begin
          state_next = S_EMIT;
        end else begin
          cmp_ok_next   = 1'b1;
          cmp_last_next = (CNT_W'(idx + 1'b1) == id_count);
          idx_next      = CNT_W'(idx + 1'b1);
        end
      end
      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // short item parser
  always_comb begin
    logic [1:0]      bl;
    logic [ID_W-1:0] val;
    kind_t           kind;
    bl                 = bytes_left;
    val                = item_value;
    kind               = item_kind;
    bytes_left_next    = bytes_left;
    item_kind_next     = item_kind;
    item_value_next    = item_value;
    usage_page_next    = usage_page;
    id_count_next      = id_count;
    overflow_seen_next = overflow_seen;
    ram_we             = 1'b0;
    ram_wdata          = item_value;
    if (clear_req) begin
      bytes_left_next    = '0;
      item_kind_next     = KIND_OTHER;
      item_value_next    = '0;
      usage_page_next    = '0;
      id_count_next      = '0;
      overflow_seen_next = 1'b0;
    end else if (byte_take) begin
      if (bytes_left == 2'd0) begin
        bl  = req.data_byte[1:0];
        val = '0;
        if (req.data_byte[7:2] == TAG_PAGE) begin
          kind = KIND_PAGE;
        end else if (req.data_byte[7:2] == TAG_RID) begin
          kind = KIND_RID;
        end else begin
          kind = KIND_OTHER;
        end
      end else begin
        bl  = bytes_left - 2'd1;
        val = {item_value[ID_W-BYTE_W-1:0], req.data_byte};
      end
      bytes_left_next = bl;
      if (bl == 2'd0) begin
        item_kind_next  = KIND_OTHER;
        item_value_next = '0;
        case (kind)
          KIND_PAGE: usage_page_next = val;
          KIND_RID: begin
            if (usage_page == vendor_page) begin
              if (id_count < CNT_W'(MAX_IDS)) begin
                ram_we        = 1'b1;
                ram_wdata     = val;
                id_count_next = CNT_W'(id_count + 1'b1);
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end else begin
        item_kind_next  = kind;
        item_value_next = val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bytes_left    <= '0;
      item_kind     <= KIND_OTHER;
      item_value    <= '0;
      usage_page    <= '0;
      id_count      <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      cmp_ok        <= 1'b0;
      cmp_last      <= 1'b0;
    end else begin
      state         <= state_next;
      bytes_left    <= bytes_left_next;
      item_kind     <= item_kind_next;
      item_value    <= item_value_next;
      usage_page    <= usage_page_next;
      id_count      <= id_count_next;
      overflow_seen <= overflow_seen_next;
      cmp_ok        <= cmp_ok_next;
      cmp_last      <= cmp_last_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    res_hit  <= res_hit_next;
    chk_byte <= chk_byte_next;
    if (out_load) begin
      out_id_valid <= res_hit;
      out_ids      <= cnt_ext[COUNT_OUT_W-1:0];
      out_ovf      <= overflow_seen;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    id_count <= CNT_W'(MAX_IDS))
    else $error("id count past table size");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (id_count == CNT_W'(MAX_IDS)))
    else $error("overflow flagged with room left in table");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (id_count < CNT_W'(MAX_IDS)))
    else $error("table write with table full");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (idx <= id_count && id_count != '0))
    else $error("check scan past recorded ids");

  a_check_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && cmp_ok && cmp_last) |=> (state == S_EMIT))
    else $error("check scan did not end after last entry");

endmodule

// ===== tb/sv/tb_hid_descriptor_report_id_filter_unit.sv =====
`timescale 1ns / 100ps
// tb_hid_descriptor_report_id_filter_unit: self-checking testbench of the report id filter
// feeds descriptor, check and clear words, predicts each status word, checks it on output
// depends on hdrf_pkg, hdrf_in_if, hdrf_out_if and the filter unit
module tb_hid_descriptor_report_id_filter_unit;
  import hdrf_pkg::*;

  localparam int TABLE_DEPTH  = MAX_IDS_DEF;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 215;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [ADDR_W-1:0] VENDOR_PAGE_ADDR = {REG_VENDOR_PAGE, 2'b00};

  typedef struct packed {
    logic                   id_valid;
    logic [COUNT_OUT_W-1:0] ids_stored;
    logic                   table_overflow;
  } status_t;

  class report_id_scoreboard;
    logic [ID_W-1:0] vendor_page;
    logic [ID_W-1:0] usage_page;
    logic [ID_W-1:0] item_value;
    logic [1:0]      bytes_left;
    kind_t           item_kind;
    logic [ID_W-1:0] id_table [TABLE_DEPTH];
    int unsigned     id_count;
    logic            overflow_seen;
    status_t         expected_status [$];
    int              errors;

    function new();
      vendor_page = VENDOR_PAGE_RESET;
      errors = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      bytes_left = '0;
      item_kind = KIND_OTHER;
      item_value = '0;
      usage_page = '0;
      id_count = 0;
      overflow_seen = 1'b0;
    endfunction

    function void commit_item();
      if (item_kind == KIND_PAGE) begin
        usage_page = item_value;
      end else if (item_kind == KIND_RID && usage_page == vendor_page) begin
        if (id_count < TABLE_DEPTH) begin
          id_table[id_count] = item_value;
          id_count++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      item_kind = KIND_OTHER;
      item_value = '0;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      if (bytes_left == 0) begin
        bytes_left = b[1:0];
        item_value = '0;
        if (b[7:2] == TAG_PAGE) item_kind = KIND_PAGE;
        else if (b[7:2] == TAG_RID) item_kind = KIND_RID;
        else item_kind = KIND_OTHER;
        if (bytes_left == 0) commit_item();
      end else begin
        item_value = {item_value[ID_W-BYTE_W-1:0], b};
        bytes_left--;
        if (bytes_left == 0) commit_item();
      end
    endfunction

    function status_t predict_status(op_t op, logic [BYTE_W-1:0] b);
      status_t s;
      s.id_valid = 1'b0;
      case (op)
        OP_CLEAR: clear_parser();
        OP_BYTE:  take_byte(b);
        OP_CHECK: begin
          for (int i = 0; i < id_count; i++)
            if (id_table[i] == {{(ID_W-BYTE_W){1'b0}}, b}) s.id_valid = 1'b1;
        end
        default: ;
      endcase
      s.ids_stored = COUNT_OUT_W'(id_count);
      s.table_overflow = overflow_seen;
      return s;
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_word(op_t op, logic [BYTE_W-1:0] b);
      expected_status.push_back(predict_status(op, b));
    endfunction

    task check_word(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("status word with nothing expected: %p", got));
      end else begin
        want = expected_status.pop_front();
        if (got.id_valid !== want.id_valid)
          report($sformatf("id_valid %b, expected %b", got.id_valid, want.id_valid));
        if (got.ids_stored !== want.ids_stored)
          report($sformatf("ids_stored %0d, expected %0d", got.ids_stored, want.ids_stored));
        if (got.table_overflow !== want.table_overflow)
          report($sformatf("table_overflow %b, expected %b",
                           got.table_overflow, want.table_overflow));
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  hdrf_in_if  req_if ();
  hdrf_out_if rsp_if ();

  report_id_scoreboard board = new();

  bit hold_off    = 1'b0;
  bit calm        = 1'b0;
  int idle_pct    = 0;
  int phase_words = 0;

  hid_descriptor_report_id_filter_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      board.check_word({rsp_if.id_valid, rsp_if.ids_stored, rsp_if.table_overflow});
  end

  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(1, 100) <= idle_pct / 2) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(op_t op, logic [BYTE_W-1:0] b);
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.data_byte <= b;
    do @(posedge clk); while (!req_if.ready);
    board.note_word(op, b);
    if (op != OP_NONE) phase_words++;
    @(negedge clk);
  endtask

  task automatic send_short_item(logic [5:0] tag, logic [1:0] size, logic [ID_W-1:0] value);
    send_word(OP_BYTE, {tag, size});
    for (int k = size; k > 0; k--) begin
      if ($urandom_range(0, 9) == 0) send_word(OP_CHECK, BYTE_W'($urandom));
      send_word(OP_BYTE, value[8*k-1 -: 8]);
    end
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_vendor_page(logic [ID_W-1:0] page);
    logic [DATA_W-1:0] rd;
    apb_write(VENDOR_PAGE_ADDR, DATA_W'(page));
    board.vendor_page = page;
    @(negedge clk);
    apb_read(VENDOR_PAGE_ADDR, rd);
    if (rd[ID_W-1:0] !== page)
      board.report($sformatf("vendor_page reads %h, expected %h", rd[ID_W-1:0], page));
  endtask

  // drop valid and wait until every status word is back
  task automatic settle();
    req_if.valid <= 1'b0;
    while (board.expected_status.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_directed();
    logic [OP_W+BYTE_W-1:0] script [25];
    script = '{
      {OP_CLEAR, 8'hFF}, {OP_CHECK, 8'h00}, {OP_CHECK, 8'hFF},
      {OP_BYTE, 8'h04}, {OP_BYTE, 8'h84},
      {OP_BYTE, 8'h05}, {OP_BYTE, 8'hFF},
      {OP_BYTE, 8'h84},
      {OP_BYTE, 8'h85}, {OP_CHECK, 8'h00}, {OP_BYTE, 8'hFF},
      {OP_BYTE, 8'h87}, {OP_BYTE, 8'h01}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h07},
      {OP_CHECK, 8'h07}, {OP_CHECK, 8'hFF},
      {OP_BYTE, 8'hFF}, {OP_BYTE, 8'hAA}, {OP_BYTE, 8'h55}, {OP_BYTE, 8'h00},
      {OP_NONE, 8'h5A}, {OP_BYTE, 8'h00},
      {OP_CLEAR, 8'h00}, {OP_CHECK, 8'hFF}
    };
    foreach (script[i]) send_word(op_t'(script[i][OP_W+BYTE_W-1:BYTE_W]), script[i][BYTE_W-1:0]);
  endtask

  task automatic random_item();
    int pick;
    logic [1:0] size;
    logic [ID_W-1:0] value;
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 99) == 0) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
    end
    pick = $urandom_range(0, 99);
    size = 2'($urandom_range(0, 3));
    value = ID_W'($urandom);
    b = BYTE_W'($urandom);
    if (pick < 40) begin
      // small one-byte ids mostly, so that checks can hit
      if ($urandom_range(0, 3) != 0) begin
        size = 2'd1;
        value = ID_W'(b);
      end
      send_short_item(TAG_RID, size, value);
    end else if (pick < 55) begin
      if ($urandom_range(0, 3) != 0) begin
        value = board.vendor_page;
        if (value > 24'h00FFFF) size = 2'd3;
        else if (value > 24'h0000FF && size < 2) size = 2'd2;
        else if (value != 0 && size == 0) size = 2'd1;
      end
      send_short_item(TAG_PAGE, size, value);
    end else if (pick < 65) begin
      send_short_item(6'($urandom), size, value);
    end else if (pick < 88) begin
      if (board.id_count > 0 && $urandom_range(0, 2) != 0)
        b = board.id_table[$urandom_range(0, board.id_count - 1)][BYTE_W-1:0];
      send_word(OP_CHECK, b);
    end else if (pick < 89) begin
      send_word(OP_CLEAR, b);
    end else if (pick < 95) begin
      send_word(OP_BYTE, b);
    end else begin
      send_word(OP_NONE, b);
    end
  endtask

  initial begin : main
    logic [ID_W-1:0] pages [PHASES];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.operation = OP_NONE;
    req_if.data_byte = '0;
    pages = '{24'h000000, 24'hFFFFFF, ID_W'($urandom), 24'h0000FF,
              ID_W'($urandom_range(0, 16'hFFFF)), ID_W'($urandom_range(0, 8'hFF))};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 15;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_vendor_page(pages[p]);
      calm = (p == PHASES - 1);
      if (p == 1) hold_off = 1'b1;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) random_item();
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.expected_status.size() != 0)
      board.report($sformatf("%0d status words never arrived", board.expected_status.size()));
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
